// File: design/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Parser phases, frame opcodes and result kind codes; no dependencies.
package wsdf_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CLOSED  = 3'd5,
    PH_HALTED  = 3'd6
  } phase_e;

  // Frame opcodes of interest
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // Result kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Header field constants
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_CNT = 3'd1;
  localparam logic [2:0] EXT64_CNT = 3'd7;
  localparam logic [2:0] KEY_CNT   = 3'd3;

  localparam logic [31:0] MAX_LEN_RESET = 32'h7fff_ffff;

endpackage

// File: design/websocket_frame_deframer.sv
// Latency: a result is valid in the cycle after the byte that causes it is accepted.
// Throughput: one received byte per cycle; a waiting result does not stall input
// as long as the downstream takes it in the same cycle.
// Reset (asynchronous, active low): parser waits for the first header byte,
// no result pending, maximum payload length set to 2147483647.
// Depends on wsdf_pkg.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // received byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        byte_present_o,
  output logic        frame_last_o
);

  logic [31:0]        max_len_q;
  wsdf_pkg::phase_e   phase_q, phase_d;
  logic [3:0]         opcode_q, opcode_d;
  logic               mask_present_q, mask_present_d;
  logic [2:0]         hdr_cnt_q, hdr_cnt_d;
  logic [63:0]        rem_len_q, rem_len_d;
  logic [31:0]        mask_key_q, mask_key_d;
  logic [1:0]         mask_idx_q, mask_idx_d;

  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic [7:0]         byte_q;
  logic               present_q, last_q;

  logic               in_fire;
  logic               emit;
  logic [1:0]         emit_kind;
  logic [7:0]         emit_byte;
  logic               emit_present;
  logic               emit_last;

  logic [6:0]         len7;
  logic [63:0]        ext_len;
  logic               ext_over;
  logic [31:0]        key_rot;
  logic [7:0]         unmasked;
  logic               rem_is_one;

  // Accept while the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign len7       = rx_byte_i[6:0];
  assign ext_len    = {rem_len_q[55:0], rx_byte_i};
  assign ext_over   = (ext_len[63:32] != 32'd0) || (ext_len[31:0] > max_len_q);
  assign key_rot    = mask_key_q << {mask_idx_q, 3'b000};
  assign unmasked   = mask_present_q ? (rx_byte_i ^ key_rot[31:24]) : rx_byte_i;
  assign rem_is_one = (rem_len_q == 64'd1);

  // Parse one byte: next state and the result it causes
  always_comb begin
    phase_d        = phase_q;
    opcode_d       = opcode_q;
    mask_present_d = mask_present_q;
    hdr_cnt_d      = hdr_cnt_q;
    rem_len_d      = rem_len_q;
    mask_key_d     = mask_key_q;
    mask_idx_d     = mask_idx_q;
    emit           = 1'b0;
    emit_kind      = wsdf_pkg::KIND_TEXT;
    emit_byte      = 8'd0;
    emit_present   = 1'b0;
    emit_last      = 1'b1;

    if (in_fire) begin
      case (phase_q)
        wsdf_pkg::PH_HDR0: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          mask_present_d = rx_byte_i[7];
          if (len7 == wsdf_pkg::LEN_EXT16 || len7 == wsdf_pkg::LEN_EXT64) begin
            rem_len_d = 64'd0;
            hdr_cnt_d = (len7 == wsdf_pkg::LEN_EXT16) ? wsdf_pkg::EXT16_CNT
                                                      : wsdf_pkg::EXT64_CNT;
            phase_d   = wsdf_pkg::PH_EXTLEN;
          end else begin
            rem_len_d = {57'd0, len7};
            if ({25'd0, len7} > max_len_q) begin
              phase_d   = wsdf_pkg::PH_HALTED;
              emit      = 1'b1;
              emit_kind = wsdf_pkg::KIND_ERROR;
            end else if (rx_byte_i[7]) begin
              mask_key_d = 32'd0;
              hdr_cnt_d  = wsdf_pkg::KEY_CNT;
              phase_d    = wsdf_pkg::PH_MASK;
            end else begin
              mask_idx_d = 2'd0;
              if (len7 != 7'd0) begin
                phase_d = wsdf_pkg::PH_PAYLOAD;
              end else begin
                phase_d = wsdf_pkg::PH_HDR0;
                if (opcode_q == wsdf_pkg::OP_TEXT) begin
                  emit = 1'b1;
                  emit_kind = wsdf_pkg::KIND_TEXT;
                end else if (opcode_q == wsdf_pkg::OP_PING) begin
                  emit = 1'b1;
                  emit_kind = wsdf_pkg::KIND_PING;
                end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
                  emit = 1'b1;
                  emit_kind = wsdf_pkg::KIND_CLOSE;
                  phase_d = wsdf_pkg::PH_CLOSED;
                end
              end
            end
          end
        end
        wsdf_pkg::PH_EXTLEN: begin
          rem_len_d = ext_len;
          if (hdr_cnt_q != 3'd0) begin
            hdr_cnt_d = hdr_cnt_q - 3'd1;
          end else if (ext_over) begin
            phase_d   = wsdf_pkg::PH_HALTED;
            emit      = 1'b1;
            emit_kind = wsdf_pkg::KIND_ERROR;
          end else if (mask_present_q) begin
            mask_key_d = 32'd0;
            hdr_cnt_d  = wsdf_pkg::KEY_CNT;
            phase_d    = wsdf_pkg::PH_MASK;
          end else begin
            mask_idx_d = 2'd0;
            if (ext_len != 64'd0) begin
              phase_d = wsdf_pkg::PH_PAYLOAD;
            end else begin
              phase_d = wsdf_pkg::PH_HDR0;
              if (opcode_q == wsdf_pkg::OP_TEXT) begin
                emit = 1'b1;
                emit_kind = wsdf_pkg::KIND_TEXT;
              end else if (opcode_q == wsdf_pkg::OP_PING) begin
                emit = 1'b1;
                emit_kind = wsdf_pkg::KIND_PING;
              end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
                emit = 1'b1;
                emit_kind = wsdf_pkg::KIND_CLOSE;
                phase_d = wsdf_pkg::PH_CLOSED;
              end
            end
          end
        end
        wsdf_pkg::PH_MASK: begin
          mask_key_d = {mask_key_q[23:0], rx_byte_i};
          if (hdr_cnt_q != 3'd0) begin
            hdr_cnt_d = hdr_cnt_q - 3'd1;
          end else begin
            mask_idx_d = 2'd0;
            if (rem_len_q != 64'd0) begin
              phase_d = wsdf_pkg::PH_PAYLOAD;
            end else begin
              phase_d = wsdf_pkg::PH_HDR0;
              if (opcode_q == wsdf_pkg::OP_TEXT) begin
                emit = 1'b1;
                emit_kind = wsdf_pkg::KIND_TEXT;
              end else if (opcode_q == wsdf_pkg::OP_PING) begin
                emit = 1'b1;
                emit_kind = wsdf_pkg::KIND_PING;
              end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
                emit = 1'b1;
                emit_kind = wsdf_pkg::KIND_CLOSE;
                phase_d = wsdf_pkg::PH_CLOSED;
              end
            end
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          mask_idx_d = mask_idx_q + 2'd1;
          rem_len_d  = rem_len_q - 64'd1;
          if (rem_is_one) begin
            phase_d = wsdf_pkg::PH_HDR0;
          end
          emit_last = rem_is_one;
          if (opcode_q == wsdf_pkg::OP_TEXT) begin
            emit         = 1'b1;
            emit_kind    = wsdf_pkg::KIND_TEXT;
            emit_byte    = unmasked;
            emit_present = 1'b1;
          end else if (opcode_q == wsdf_pkg::OP_PING) begin
            emit         = 1'b1;
            emit_kind    = wsdf_pkg::KIND_PING;
            emit_byte    = unmasked;
            emit_present = 1'b1;
          end else if (opcode_q == wsdf_pkg::OP_CLOSE && rem_is_one) begin
            emit      = 1'b1;
            emit_kind = wsdf_pkg::KIND_CLOSE;
            phase_d   = wsdf_pkg::PH_CLOSED;
          end
        end
        default: begin
          // closed or halted: drop everything until reset
        end
      endcase
    end
  end

  // Parser state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q      <= wsdf_pkg::MAX_LEN_RESET;
      phase_q        <= wsdf_pkg::PH_HDR0;
      opcode_q       <= 4'd0;
      mask_present_q <= 1'b0;
      hdr_cnt_q      <= 3'd0;
      rem_len_q      <= 64'd0;
      mask_key_q     <= 32'd0;
      mask_idx_q     <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      phase_q        <= phase_d;
      opcode_q       <= opcode_d;
      mask_present_q <= mask_present_d;
      hdr_cnt_q      <= hdr_cnt_d;
      rem_len_q      <= rem_len_d;
      mask_key_q     <= mask_key_d;
      mask_idx_q     <= mask_idx_d;
    end
  end

  // Result register: load on a new result, drop once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q    <= emit_kind;
      byte_q    <= emit_byte;
      present_q <= emit_present;
      last_q    <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign payload_byte_o = byte_q;
  assign byte_present_o = present_q;
  assign frame_last_o   = last_q;

`ifndef ASSERT_OFF
  // A closed or halted parser never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (phase_q == wsdf_pkg::PH_CLOSED || phase_q == wsdf_pkg::PH_HALTED))
      |-> !emit)
    else $error("result produced after close or halt");

  // An oversize error leaves the parser halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit && emit_kind == wsdf_pkg::KIND_ERROR)
      |=> (phase_q == wsdf_pkg::PH_HALTED))
    else $error("parser not halted after oversize error");

  // Payload phase always has bytes left to consume
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsdf_pkg::PH_PAYLOAD) |-> (rem_len_q != 64'd0))
    else $error("payload phase with zero remaining length");

  // Event results carry no byte and close their frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == wsdf_pkg::KIND_ERROR || kind_q == wsdf_pkg::KIND_CLOSE))
      |-> (last_q && !present_q && byte_q == 8'd0))
    else $error("malformed close or error result");
`endif

endmodule

// File: verif/websocket_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer: random frames against a predictor.
// Depends on wsdf_pkg and the websocket_frame_deframer RTL.
module websocket_frame_deframer_tb;

  localparam int unsigned QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       present;
    logic       last;
  } deframed_result_t;

  // Predicts deframer results and holds those not yet delivered
  class frame_scoreboard;
    wsdf_pkg::phase_e phase;
    logic [3:0]       opcode;
    logic             masked;
    logic [2:0]       hdr_left;
    logic [63:0]      remaining;
    logic [31:0]      key;
    logic [1:0]       key_idx;
    logic [31:0]      max_len;
    deframed_result_t pending_results[$];
    int unsigned      errors;

    function new();
      phase     = wsdf_pkg::PH_HDR0;
      opcode    = '0;
      masked    = 1'b0;
      hdr_left  = '0;
      remaining = '0;
      key       = '0;
      key_idx   = '0;
      max_len   = wsdf_pkg::MAX_LEN_RESET;
      errors    = 0;
    endfunction

    function void set_max_len(logic [31:0] v);
      max_len = v;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] data, logic present, logic last);
      deframed_result_t r;
      r.kind    = kind;
      r.data    = data;
      r.present = present;
      r.last    = last;
      pending_results.push_back(r);
    endfunction

    // Header done: enter payload, or close out an empty frame
    function void end_header();
      key_idx = '0;
      if (remaining != 0) begin
        phase = wsdf_pkg::PH_PAYLOAD;
      end else begin
        phase = wsdf_pkg::PH_HDR0;
        if (opcode == wsdf_pkg::OP_TEXT) begin
          push(wsdf_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b1);
        end else if (opcode == wsdf_pkg::OP_PING) begin
          push(wsdf_pkg::KIND_PING, 8'h00, 1'b0, 1'b1);
        end else if (opcode == wsdf_pkg::OP_CLOSE) begin
          phase = wsdf_pkg::PH_CLOSED;
          push(wsdf_pkg::KIND_CLOSE, 8'h00, 1'b0, 1'b1);
        end
      end
    endfunction

    // Length complete: check against the limit, then key or payload
    function void length_done();
      if (remaining > 64'(max_len)) begin
        phase = wsdf_pkg::PH_HALTED;
        push(wsdf_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1);
      end else if (masked) begin
        key      = '0;
        hdr_left = wsdf_pkg::KEY_CNT;
        phase    = wsdf_pkg::PH_MASK;
      end else begin
        end_header();
      end
    endfunction

    function void take_rx_byte(logic [7:0] b);
      logic [7:0] data;
      logic       last;
      case (phase)
        wsdf_pkg::PH_HDR0: begin
          opcode = b[3:0];
          phase  = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          masked = b[7];
          if (b[6:0] == wsdf_pkg::LEN_EXT16 || b[6:0] == wsdf_pkg::LEN_EXT64) begin
            remaining = '0;
            hdr_left  = (b[6:0] == wsdf_pkg::LEN_EXT16) ? wsdf_pkg::EXT16_CNT
                                                        : wsdf_pkg::EXT64_CNT;
            phase     = wsdf_pkg::PH_EXTLEN;
          end else begin
            remaining = 64'(b[6:0]);
            length_done();
          end
        end
        wsdf_pkg::PH_EXTLEN: begin
          remaining = {remaining[55:0], b};
          if (hdr_left != 0) hdr_left = hdr_left - 3'd1;
          else length_done();
        end
        wsdf_pkg::PH_MASK: begin
          key = {key[23:0], b};
          if (hdr_left != 0) hdr_left = hdr_left - 3'd1;
          else end_header();
        end
        wsdf_pkg::PH_PAYLOAD: begin
          data      = masked ? (b ^ 8'(key >> (24 - 8 * key_idx))) : b;
          key_idx   = key_idx + 2'd1;
          remaining = remaining - 64'd1;
          last      = (remaining == 0);
          if (last) phase = wsdf_pkg::PH_HDR0;
          if (opcode == wsdf_pkg::OP_TEXT) begin
            push(wsdf_pkg::KIND_TEXT, data, 1'b1, last);
          end else if (opcode == wsdf_pkg::OP_PING) begin
            push(wsdf_pkg::KIND_PING, data, 1'b1, last);
          end else if (opcode == wsdf_pkg::OP_CLOSE && last) begin
            phase = wsdf_pkg::PH_CLOSED;
            push(wsdf_pkg::KIND_CLOSE, 8'h00, 1'b0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic present,
                               logic last);
      deframed_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_kind %0d payload_byte %02h", kind, data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, kind);
          errors++;
        end
        if (data !== want.data) begin
          $error("payload_byte: expected %02h, got %02h", want.data, data);
          errors++;
        end
        if (present !== want.present) begin
          $error("byte_present: expected %0b, got %0b", want.present, present);
          errors++;
        end
        if (last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  payload_byte_o;
  logic        byte_present_o;
  logic        frame_last_o;

  frame_scoreboard sb = new();
  int unsigned     send_gap_pct;
  int unsigned     stall_pct;
  int unsigned     bytes_sent;

  // Short opening stream: empty text, empty masked ping, text with FIN and RSV set,
  // masked binary frame (dropped), ping with a 16-bit length and FIN clear
  logic [7:0] opening_bytes [$] = '{
    8'h81, 8'h00,
    8'h89, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78,
    8'hF1, 8'h02, 8'h00, 8'hFF,
    8'h02, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hC3,
    8'h09, 8'hFE, 8'h00, 8'h01, 8'h7E
  };

  websocket_frame_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .byte_present_o (byte_present_o),
    .frame_last_o   (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stall the result channel at random, changing on the falling edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(result_kind_o, payload_byte_o, byte_present_o, frame_last_o);
  end

  // Abort when no transaction has moved for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one byte, called and returning on a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_rx_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every predicted result has been taken
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max_len(input logic [31:0] v);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_max_len(v);
  endtask

  function automatic logic [7:0] random_byte();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Send one frame; payload is cut short to 16 bytes only for lengths above 4096
  task automatic send_frame(input logic [3:0] opc, input longint unsigned len,
                            input logic masked);
    int          enc;
    longint unsigned body;
    if (len <= 125) enc = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    else if (len <= 65535) enc = $urandom_range(1, 2);
    else enc = 2;
    send_byte({4'($urandom_range(15)), opc});
    case (enc)
      0: send_byte({masked, 7'(len)});
      1: begin
        send_byte({masked, wsdf_pkg::LEN_EXT16});
        send_byte(8'(len >> 8));
        send_byte(8'(len));
      end
      default: begin
        send_byte({masked, wsdf_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(8'(len >> (8 * i)));
      end
    endcase
    if (masked) begin
      for (int i = 0; i < 4; i++) send_byte(random_byte());
    end
    body = (len > 4096) ? 16 : len;
    for (longint unsigned i = 0; i < body; i++) send_byte(random_byte());
  endtask

  function automatic logic [3:0] pick_opcode();
    int unsigned r;
    logic [3:0]  opc;
    r = $urandom_range(99);
    if (r < 45) return wsdf_pkg::OP_TEXT;
    if (r < 75) return wsdf_pkg::OP_PING;
    do opc = 4'($urandom_range(15));
    while (opc == wsdf_pkg::OP_TEXT || opc == wsdf_pkg::OP_PING ||
           opc == wsdf_pkg::OP_CLOSE);
    return opc;
  endfunction

  task automatic set_idling(input int unsigned gap, input int unsigned stall);
    send_gap_pct = gap;
    stall_pct    = stall;
  endtask

  // Random frames within the length limit until the byte budget is spent
  task automatic random_frames(input int unsigned budget, input longint unsigned limit,
                               input bit mixed_idling);
    int unsigned     stop_at;
    int unsigned     r;
    longint unsigned cap;
    longint unsigned len;
    stop_at = bytes_sent + budget;
    cap     = (limit > 150) ? 150 : limit;
    while (bytes_sent < stop_at) begin
      if (mixed_idling) begin
        case ($urandom_range(3))
          0: set_idling(0, 0);
          1: set_idling(73, 0);
          2: set_idling(0, 73);
          default: set_idling(12, 12);
        endcase
      end
      r = $urandom_range(99);
      if (cap == 0 || r < 15) len = 0;
      else if (r < 25) len = cap;
      else if (r < 30) len = 64'($urandom_range(1, int'(cap)));
      else len = 64'($urandom_range(1, (cap > 20) ? 20 : int'(cap)));
      send_frame(pick_opcode(), len, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    longint unsigned limit;
    longint unsigned len;
    logic [31:0]     hi;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    bytes_sent   = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset limit, no idling
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    random_frames(100, 64'(wsdf_pkg::MAX_LEN_RESET), 1'b0);

    // Widest limit, sender gaps
    write_max_len(32'hFFFF_FFFF);
    set_idling(73, 0);
    random_frames(100, 64'hFFFF_FFFF, 1'b0);

    // Zero limit: only empty frames pass; pause once mid-phase until drained
    write_max_len(32'h0);
    set_idling(0, 73);
    random_frames(40, 0, 1'b0);
    drain();
    random_frames(40, 0, 1'b0);

    // Small limit, frames often exactly at it
    limit = 64'($urandom_range(1, 40));
    write_max_len(32'(limit));
    set_idling(12, 12);
    random_frames(100, limit, 1'b0);

    // Large random limit, idling varied per frame
    limit = 64'($urandom_range(300, 32'hFFFF_FFFE));
    write_max_len(32'(limit));
    random_frames(140, limit, 1'b1);

    // End the stream with a close frame or an oversize frame, then trailing bytes
    if ($urandom_range(1) == 0) begin
      send_frame(wsdf_pkg::OP_CLOSE, 64'($urandom_range(0, 10)),
                 1'($urandom_range(1)));
    end else begin
      if ($urandom_range(1) == 0) begin
        len = limit + 1;
      end else begin
        hi  = $urandom_range(1, 32'hFFFF_FFFF);
        len = {hi, 32'($urandom)};
      end
      send_frame(4'($urandom_range(15)), len, 1'($urandom_range(1)));
    end
    repeat (12) send_byte(random_byte());

    drain();
    set_idling(0, 0);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/wsdf_pkg.sv
design/websocket_frame_deframer.sv
verif/websocket_frame_deframer_tb.sv
